FILE: rtl/block_buffer_pool_logger_macros.svh
// assertion macros for the block buffer pool logger
`ifndef BLOCK_BUFFER_POOL_LOGGER_MACROS_SVH
`define BLOCK_BUFFER_POOL_LOGGER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define BBPL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must be followed by a result in the next cycle
`define BBPL_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define BBPL_ASSERT(lbl, clk, rst, prop, msg)
`define BBPL_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: rtl/bbpl_pkg.sv
// shared types and constants of the block buffer pool logger
package bbpl_pkg;

   localparam int DEFAULT_BLOCK_BYTES = 512;
   localparam int DEFAULT_BLOCK_COUNT = 30;
   localparam int DEFAULT_QUEUE_DEPTH = 32;

   localparam int IDX_W  = 5;
   localparam int SYNC_W = 17;

   localparam logic [SYNC_W-1:0] SYNC_MAX          = 17'h1FFFF;
   localparam logic [15:0]       OVERRUN_MAX       = 16'hFFFF;
   localparam logic [7:0]        OPEN_FAIL_MAX     = 8'hFF;
   localparam logic [15:0]       SYNC_INTERVAL_RST = 16'd64;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_DRAIN = 2'd1,
      ACT_CLOSE = 2'd2
   } action_type;

   typedef enum logic {
      REG_LOGGING_ENABLED = 1'b0,
      REG_SYNC_INTERVAL   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic        logging_enabled;
      logic [15:0] sync_interval;
      logic        sync_clear;
   } cfg_type;

   typedef struct packed {
      logic store_we;
      logic read_en;
      logic fill_we;
   } mem_ctl_type;

   typedef struct packed {
      logic        write_accepted;
      logic        read_valid;
      logic        read_last;
      logic        sync_request;
      logic [4:0]  full_blocks;
      logic [15:0] overrun_total;
      logic [7:0]  open_fail_total;
   } rsp_info_type;

endpackage

FILE: rtl/bbpl_csr.sv
// configuration registers behind the apb-style port
module bbpl_csr
   import bbpl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic        enabled_ff, enabled_in;
   logic [15:0] interval_ff, interval_in;
   logic        clear_ff, clear_in;
   logic        wr_en;
   reg_index_type index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = reg_index_type'(paddr[2]);

   always_comb begin
      enabled_in  = enabled_ff;
      interval_in = interval_ff;
      clear_in    = 1'b0;
      if (wr_en) begin
         case (index)
            REG_LOGGING_ENABLED: begin
               enabled_in = pwdata[0];
               clear_in   = pwdata[0];
            end
            REG_SYNC_INTERVAL: interval_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         interval_ff <= SYNC_INTERVAL_RST;
         clear_ff    <= 1'b0;
      end else begin
         enabled_ff  <= enabled_in;
         interval_ff <= interval_in;
         clear_ff    <= clear_in;
      end
   end

   always_comb begin
      case (index)
         REG_LOGGING_ENABLED: prdata = {31'b0, enabled_ff};
         REG_SYNC_INTERVAL:   prdata = {16'b0, interval_ff};
         default:             prdata = '0;
      endcase
   end

   assign cfg.logging_enabled = enabled_ff;
   assign cfg.sync_interval   = interval_ff;
   assign cfg.sync_clear      = clear_ff;

endmodule

FILE: rtl/bbpl_store.sv
// block byte memory and fill length memory, registered read
module bbpl_store
   import bbpl_pkg::*;
#(
   parameter int BLOCK_BYTES = DEFAULT_BLOCK_BYTES,
   parameter int BLOCK_COUNT = DEFAULT_BLOCK_COUNT
) (
   input  logic                                    clock,
   input  mem_ctl_type                             mem_ctl,
   input  logic [$clog2(BLOCK_COUNT*BLOCK_BYTES)-1:0] store_addr,
   input  logic [7:0]                              store_wdata,
   input  logic [IDX_W-1:0]                        fill_addr,
   input  logic [$clog2(BLOCK_BYTES+1)-1:0]        fill_wdata,
   output logic [7:0]                              byte_rd,
   output logic [$clog2(BLOCK_BYTES+1)-1:0]        fill_rd
);

   localparam int DEPTH = BLOCK_COUNT * BLOCK_BYTES;
   localparam int LW    = $clog2(BLOCK_BYTES + 1);
   localparam int FW    = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

   logic [7:0]    store_mem [DEPTH];
   logic [LW-1:0] fill_mem  [BLOCK_COUNT];
   logic [7:0]    byte_rd_ff;
   logic [LW-1:0] fill_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.store_we) begin
         store_mem[store_addr] <= store_wdata;
      end
      if (mem_ctl.read_en) begin
         byte_rd_ff <= store_mem[store_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.fill_we) begin
         fill_mem[fill_addr[FW-1:0]] <= fill_wdata;
      end
      if (mem_ctl.read_en) begin
         fill_rd_ff <= fill_mem[fill_addr[FW-1:0]];
      end
   end

   assign byte_rd = byte_rd_ff;
   assign fill_rd = fill_rd_ff;

endmodule

FILE: rtl/bbpl_ctrl.sv
// queue pointers, open block tracking, counters and memory request generation
`include "block_buffer_pool_logger_macros.svh"
module bbpl_ctrl
   import bbpl_pkg::*;
#(
   parameter int BLOCK_BYTES = DEFAULT_BLOCK_BYTES,
   parameter int BLOCK_COUNT = DEFAULT_BLOCK_COUNT,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       accept,
   input  logic [1:0]                                 action,
   input  logic [7:0]                                 data_byte,
   input  cfg_type                                    cfg,
   output rsp_info_type                               info,
   output logic [$clog2(BLOCK_BYTES)-1:0]             drain_pos,
   output mem_ctl_type                                mem_ctl,
   output logic [$clog2(BLOCK_COUNT*BLOCK_BYTES)-1:0] store_addr,
   output logic [7:0]                                 store_wdata,
   output logic [IDX_W-1:0]                           fill_addr,
   output logic [$clog2(BLOCK_BYTES+1)-1:0]           fill_wdata
);

   localparam int POOL = (BLOCK_COUNT < QUEUE_DEPTH) ? BLOCK_COUNT : QUEUE_DEPTH;
   localparam int PW   = $clog2(BLOCK_BYTES);
   localparam int LW   = $clog2(BLOCK_BYTES + 1);
   localparam int AW   = $clog2(BLOCK_COUNT * BLOCK_BYTES);
   localparam int QW   = $clog2(QUEUE_DEPTH);
   localparam int CW   = $clog2(QUEUE_DEPTH + 1);

   logic [IDX_W-1:0]  free_q_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]  full_q_ff [QUEUE_DEPTH];
   logic [QW-1:0]     free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [QW-1:0]     full_head_ff, full_head_in, full_tail_ff, full_tail_in;
   logic [CW-1:0]     free_used_ff, free_used_in, full_used_ff, full_used_in;
   logic              block_open_ff, block_open_in;
   logic [IDX_W-1:0]  open_index_ff, open_index_in;
   logic [PW-1:0]     write_pos_ff, write_pos_in;
   logic [PW-1:0]     drain_pos_ff, drain_pos_in;
   logic [SYNC_W-1:0] sync_count_ff, sync_count_in;
   logic [15:0]       overrun_ff, overrun_in;
   logic [7:0]        open_fail_ff, open_fail_in;
   logic              free_push, full_push;
   logic [IDX_W-1:0]  push_blk;

   function automatic logic [QW-1:0] qnext(input logic [QW-1:0] p);
      return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
   endfunction

   function automatic logic [IDX_W-1:0] blk(input logic [IDX_W-1:0] b);
      return (b < IDX_W'(BLOCK_COUNT)) ? b : '0;
   endfunction

   function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] b,
                                             input logic [PW-1:0] p);
      return AW'(b) * AW'(BLOCK_BYTES) + AW'(p);
   endfunction

   always_comb begin
      logic              open_now;
      logic [IDX_W-1:0]  b;
      logic [PW-1:0]     pos;
      logic [LW-1:0]     wnext;
      logic [SYNC_W-1:0] sc_base;
      logic [SYNC_W-1:0] sc_inc;
      // a pending clear from a logging enable write counts as already applied
      sc_base       = cfg.sync_clear ? '0 : sync_count_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_used_in  = free_used_ff;
      full_head_in  = full_head_ff;
      full_tail_in  = full_tail_ff;
      full_used_in  = full_used_ff;
      block_open_in = block_open_ff;
      open_index_in = open_index_ff;
      write_pos_in  = write_pos_ff;
      drain_pos_in  = drain_pos_ff;
      sync_count_in = sc_base;
      overrun_in    = overrun_ff;
      open_fail_in  = open_fail_ff;
      free_push     = 1'b0;
      full_push     = 1'b0;
      push_blk      = '0;
      mem_ctl       = '0;
      store_addr    = '0;
      fill_addr     = '0;
      fill_wdata    = '0;
      info          = '0;
      open_now      = block_open_ff;
      b             = open_index_ff;
      pos           = write_pos_ff;
      wnext         = LW'(write_pos_ff) + LW'(1);
      sc_inc        = (sc_base == SYNC_MAX) ? sc_base : sc_base + SYNC_W'(1);

      if (accept) begin
         case (action_type'(action))
            ACT_WRITE: begin
               if (!block_open_ff) begin
                  if (free_used_ff != '0) begin
                     b            = blk(free_q_ff[free_tail_ff]);
                     free_tail_in = qnext(free_tail_ff);
                     free_used_in = free_used_ff - CW'(1);
                     open_now     = 1'b1;
                     pos          = '0;
                  end else if (open_fail_ff != OPEN_FAIL_MAX) begin
                     open_fail_in = open_fail_ff + 8'd1;
                  end
               end
               if (!open_now) begin
                  if (overrun_ff != OVERRUN_MAX) begin
                     overrun_in = overrun_ff + 16'd1;
                  end
               end else begin
                  mem_ctl.store_we    = 1'b1;
                  store_addr          = addr_of(b, pos);
                  info.write_accepted = 1'b1;
                  wnext               = LW'(pos) + LW'(1);
                  if (wnext == LW'(BLOCK_BYTES)) begin
                     // block filled: hand it to the full queue
                     mem_ctl.fill_we = 1'b1;
                     fill_addr       = b;
                     fill_wdata      = wnext;
                     if (full_used_ff < CW'(QUEUE_DEPTH)) begin
                        full_push    = 1'b1;
                        push_blk     = b;
                        full_head_in = qnext(full_head_ff);
                        full_used_in = full_used_ff + CW'(1);
                     end
                     block_open_in = 1'b0;
                     write_pos_in  = '0;
                     open_fail_in  = '0;
                  end else begin
                     block_open_in = 1'b1;
                     open_index_in = b;
                     write_pos_in  = pos + PW'(1);
                  end
               end
            end
            ACT_DRAIN: begin
               if (full_used_ff != '0) begin
                  b               = blk(full_q_ff[full_tail_ff]);
                  info.read_valid = 1'b1;
                  mem_ctl.read_en = 1'b1;
                  store_addr      = addr_of(b, drain_pos_ff);
                  fill_addr       = b;
                  if (drain_pos_ff == PW'(BLOCK_BYTES - 1)) begin
                     info.read_last = 1'b1;
                     drain_pos_in   = '0;
                     sync_count_in  = sc_inc;
                     if (free_used_ff < CW'(QUEUE_DEPTH)) begin
                        free_push    = 1'b1;
                        push_blk     = b;
                        free_head_in = qnext(free_head_ff);
                        free_used_in = free_used_ff + CW'(1);
                     end
                     full_tail_in = qnext(full_tail_ff);
                     full_used_in = full_used_ff - CW'(1);
                     if (cfg.logging_enabled && (sc_inc > {1'b0, cfg.sync_interval})) begin
                        info.sync_request = 1'b1;
                        sync_count_in     = '0;
                     end
                  end else begin
                     drain_pos_in = drain_pos_ff + PW'(1);
                  end
               end
            end
            ACT_CLOSE: begin
               if (block_open_ff) begin
                  mem_ctl.fill_we = 1'b1;
                  fill_addr       = blk(open_index_ff);
                  fill_wdata      = LW'(write_pos_ff);
                  if (full_used_ff < CW'(QUEUE_DEPTH)) begin
                     full_push    = 1'b1;
                     push_blk     = blk(open_index_ff);
                     full_head_in = qnext(full_head_ff);
                     full_used_in = full_used_ff + CW'(1);
                  end
                  block_open_in = 1'b0;
                  write_pos_in  = '0;
                  open_fail_in  = '0;
               end
            end
            default: ;
         endcase
      end

      info.full_blocks     = 5'(full_used_in);
      info.overrun_total   = overrun_in;
      info.open_fail_total = open_fail_in;
   end

   assign drain_pos   = drain_pos_ff;
   assign store_wdata = data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= QW'(POOL % QUEUE_DEPTH);
         free_tail_ff  <= '0;
         free_used_ff  <= CW'(POOL);
         full_head_ff  <= '0;
         full_tail_ff  <= '0;
         full_used_ff  <= '0;
         block_open_ff <= 1'b0;
         open_index_ff <= '0;
         write_pos_ff  <= '0;
         drain_pos_ff  <= '0;
         sync_count_ff <= '0;
         overrun_ff    <= '0;
         open_fail_ff  <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_used_ff  <= free_used_in;
         full_head_ff  <= full_head_in;
         full_tail_ff  <= full_tail_in;
         full_used_ff  <= full_used_in;
         block_open_ff <= block_open_in;
         open_index_ff <= open_index_in;
         write_pos_ff  <= write_pos_in;
         drain_pos_ff  <= drain_pos_in;
         sync_count_ff <= sync_count_in;
         overrun_ff    <= overrun_in;
         open_fail_ff  <= open_fail_in;
      end
   end

   // free queue starts holding the pool indices in order
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            free_q_ff[i] <= (i < POOL) ? IDX_W'(i) : '0;
         end
      end else if (free_push) begin
         free_q_ff[free_head_ff] <= push_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (full_push) begin
         full_q_ff[full_head_ff] <= push_blk;
      end
   end

   `BBPL_ASSERT(a_pool_conserved, clock, reset, (32'(free_used_ff) + 32'(full_used_ff) + 32'(block_open_ff)) == POOL, "block lost or duplicated across queues")
   `BBPL_ASSERT(a_closed_pos_zero, clock, reset, !block_open_ff |-> (write_pos_ff == '0), "write position set with no open block")
   `BBPL_ASSERT(a_drain_needs_full, clock, reset, (drain_pos_ff != '0) |-> (full_used_ff != '0), "drain position set with full queue empty")
   `BBPL_ASSERT_NEXT(a_sync_clears, clock, reset, (accept && info.sync_request), (sync_count_ff == '0), "sync count not cleared after sync request")

endmodule

FILE: rtl/block_buffer_pool_logger.sv
// top level of the block buffer pool logger
//
//   channel   ports                      direction  transfer when
//   request   req_action, req_data_byte  in         req_valid && req_ready
//   response  rsp_* result fields        out        rsp_valid && rsp_ready
//   config    psel .. pready (apb)       in/out     psel && penable && pwrite
//
// one request taken per cycle while req_ready is high; the registered block memory
// read fills the read stage and the output register then puts its response on
// rsp_valid, from where it transfers once rsp_ready is high
// reset clears pointers and counters at once; the byte and fill length memories
// need no clearing pass since bytes past a block's fill length read as zero
// a stalled response holds the output register and one request in the read
// stage; req_ready drops only when both are occupied and rsp_ready is low
module block_buffer_pool_logger
   import bbpl_pkg::*;
#(
   parameter int BLOCK_BYTES = DEFAULT_BLOCK_BYTES,
   parameter int BLOCK_COUNT = DEFAULT_BLOCK_COUNT,
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_accepted,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_last,
   output logic        rsp_sync_request,
   output logic [4:0]  rsp_full_blocks,
   output logic [15:0] rsp_overrun_total,
   output logic [7:0]  rsp_open_fail_total,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int PW = $clog2(BLOCK_BYTES);
   localparam int LW = $clog2(BLOCK_BYTES + 1);
   localparam int AW = $clog2(BLOCK_COUNT * BLOCK_BYTES);

   cfg_type          cfg;
   rsp_info_type     info;
   mem_ctl_type      mem_ctl;
   logic [PW-1:0]    drain_pos;
   logic [AW-1:0]    store_addr;
   logic [7:0]       store_wdata;
   logic [IDX_W-1:0] fill_addr;
   logic [LW-1:0]    fill_wdata;
   logic [7:0]       byte_rd;
   logic [LW-1:0]    fill_rd;
   logic             accept;
   logic             advance;

   // read stage: request state already committed, memory data on its way
   logic             s1_valid_ff, s1_valid_in;
   rsp_info_type     s1_info_ff;
   logic [PW-1:0]    s1_pos_ff;
   logic [7:0]       s1_byte;

   // output register
   logic             out_valid_ff, out_valid_in;
   rsp_info_type     out_info_ff;
   logic [7:0]       out_byte_ff;

   bbpl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bbpl_ctrl #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .BLOCK_COUNT (BLOCK_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .data_byte   (req_data_byte),
      .cfg         (cfg),
      .info        (info),
      .drain_pos   (drain_pos),
      .mem_ctl     (mem_ctl),
      .store_addr  (store_addr),
      .store_wdata (store_wdata),
      .fill_addr   (fill_addr),
      .fill_wdata  (fill_wdata)
   );

   bbpl_store #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .BLOCK_COUNT (BLOCK_COUNT)
   ) u_store (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .store_addr  (store_addr),
      .store_wdata (store_wdata),
      .fill_addr   (fill_addr),
      .fill_wdata  (fill_wdata),
      .byte_rd     (byte_rd),
      .fill_rd     (fill_rd)
   );

   // the output register frees when empty or when its transfer completes
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // unwritten tail of a closed block reads as zero
   assign s1_byte = (s1_info_ff.read_valid && (LW'(s1_pos_ff) < fill_rd)) ? byte_rd : 8'd0;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
         s1_pos_ff  <= drain_pos;
      end
      if (advance && s1_valid_ff) begin
         out_info_ff <= s1_info_ff;
         out_byte_ff <= s1_byte;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_write_accepted  = out_info_ff.write_accepted;
   assign rsp_read_valid      = out_info_ff.read_valid;
   assign rsp_read_byte       = out_byte_ff;
   assign rsp_read_last       = out_info_ff.read_last;
   assign rsp_sync_request    = out_info_ff.sync_request;
   assign rsp_full_blocks     = out_info_ff.full_blocks;
   assign rsp_overrun_total   = out_info_ff.overrun_total;
   assign rsp_open_fail_total = out_info_ff.open_fail_total;

endmodule
